FILE: design/mbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
`default_nettype none
package mbp_pkg;

   localparam int MAX_FIELD_BITS = 32;
   localparam int FIELD_LIMIT    = (MAX_FIELD_BITS > 32) ? 32 : MAX_FIELD_BITS;
   localparam int BYTE_BITS      = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] field_value;
      logic [5:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // Bytes of one request, first byte in the top bits, and how many are valid.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
   } entry_type;

   typedef struct packed {
      logic      valid;
      logic      full;
      entry_type data;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: design/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: front end, queue and byte sender.
//
// Requests arrive on req_valid/req_ready with a req_data struct. An append request
// (func clear) adds the low bit_count bits of field_value, highest bit first, to a
// byte stream that fills each byte from bit 7 down; bit_count above 32 counts as 32
// and zero appends nothing. A flush request (func set) sends the pending partial byte
// padded with zeros, or nothing when no bits are pending.
// Bytes leave on rsp_valid/rsp_ready, one per cycle while the receiver is ready, and
// last_of_run marks the final byte of each request. A request that completes no byte
// gives no response. The front end takes one request per cycle while the two-entry
// queue has room. The byte sender drains one byte per cycle while the receiver is
// ready, so the sustained rate is one byte per cycle. The first byte of a request
// passes through the queue entry and then the sender's word register before it shows
// on rsp_valid. When the receiver stalls, the current byte holds and the queue fills;
// once it is full, req_ready drops until the sender frees an entry.
// Reset is synchronous and clears the pending bits, the queue and the sender.
`default_nettype none
module msb_first_bit_packer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mbp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mbp_pkg::rsp_type      rsp_data
);

   mbp_pkg::entry_type        q_entry;
   mbp_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;

   // Merges each request with the leftover bits and forms the bytes it completes.
   mbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_status.full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // Decouples request acceptance from byte output.
   mbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .status    (q_status)
   );

   // Sends the queued bytes in stream order.
   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: design/mbp_front.sv
// Front end: merges each request with the pending bits and forms its output bytes.
`default_nettype none
module mbp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mbp_pkg::req_type  req_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output mbp_pkg::entry_type     q_entry
);

   localparam logic [5:0] LIMIT = 6'(mbp_pkg::FIELD_LIMIT);

   logic [6:0]  pend_bits_ff, pend_bits_in;
   logic [2:0]  pend_cnt_ff, pend_cnt_in;
   logic [5:0]  n_sat;
   logic [31:0] value_masked;
   logic [38:0] combined;
   logic [38:0] aligned;
   logic [5:0]  total;
   logic [2:0]  rem;
   logic [2:0]  nbytes;
   logic [7:0]  rem_mask;
   logic [7:0]  flush_byte;
   logic        accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      n_sat        = (req_data.bit_count > LIMIT) ? LIMIT : req_data.bit_count;
      value_masked = (n_sat == 6'd0) ? 32'd0
                   : (req_data.field_value & (32'hFFFF_FFFF >> (6'd32 - n_sat)));
      combined     = ({32'd0, pend_bits_ff} << n_sat) | {7'd0, value_masked};
      total        = {3'd0, pend_cnt_ff} + n_sat;
      rem          = total[2:0];
      nbytes       = total[5:3];
      aligned      = combined >> rem;
      rem_mask     = (8'd1 << rem) - 8'd1;
      flush_byte   = {1'b0, pend_bits_ff} << (4'd8 - {1'b0, pend_cnt_ff});

      if (req_data.func == mbp_pkg::FUNC_FLUSH) begin
         q_entry.word   = {flush_byte, 24'd0};
         q_entry.nbytes = (pend_cnt_ff != 3'd0) ? 3'd1 : 3'd0;
         pend_bits_in   = 7'd0;
         pend_cnt_in    = 3'd0;
      end else begin
         q_entry.word   = aligned[31:0] << {3'd4 - nbytes, 3'b000};
         q_entry.nbytes = nbytes;
         pend_bits_in   = combined[6:0] & rem_mask[6:0];
         pend_cnt_in    = rem;
      end
      q_push = accept && (q_entry.nbytes != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= 7'd0;
         pend_cnt_ff  <= 3'd0;
      end else if (accept) begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.func == mbp_pkg::FUNC_FLUSH |=> pend_cnt_ff == 3'd0)
      else $error("pending bits survived a flush");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_entry.nbytes >= 3'd1 && q_entry.nbytes <= 3'd4)
      else $error("queued byte count out of range");

   a_unused_low_zero: assert property (@(posedge clock) disable iff (reset)
      (pend_bits_ff & ~((7'd1 << pend_cnt_ff) - 7'd1)) == 7'd0)
      else $error("stale bits above the pending count");

endmodule
`default_nettype wire

FILE: design/mbp_queue.sv
// Two-entry queue between the front end and the byte sender.
`default_nettype none
module mbp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mbp_pkg::entry_type   push_data,
   input  wire logic                 pop,
   output mbp_pkg::queue_status_type status
);

   mbp_pkg::entry_type mem_ff [mbp_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      status.valid = count_ff != 2'd0;
      status.full  = count_ff == 2'(mbp_pkg::QUEUE_DEPTH);
      status.data  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid)
      else $error("pop from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(mbp_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: design/mbp_back.sv
// Back end: sends queued bytes one per ready cycle and marks the last of each request.
`default_nettype none
module mbp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mbp_pkg::queue_status_type q_status,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output mbp_pkg::rsp_type              rsp_data
);

   logic [31:0] word_ff, word_in;
   logic [2:0]  remain_ff, remain_in;
   logic        take;

   always_comb begin
      rsp_valid            = remain_ff != 3'd0;
      rsp_data.out_byte    = word_ff[31:24];
      rsp_data.last_of_run = remain_ff == 3'd1;
      take  = rsp_valid && rsp_ready;
      q_pop = q_status.valid && ((remain_ff == 3'd0) || (remain_ff == 3'd1 && take));
      word_in   = word_ff;
      remain_in = remain_ff;
      if (q_pop) begin
         word_in   = q_status.data.word;
         remain_in = q_status.data.nbytes;
      end else if (take) begin
         word_in   = {word_ff[23:0], 8'd0};
         remain_in = remain_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 3'd0;
      end else begin
         remain_ff <= remain_in;
      end
      word_ff <= word_in;
   end

   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> remain_ff != 3'd0)
      else $error("loaded an entry without bytes");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> remain_ff == 3'd0 || take)
      else $error("entry loaded over unsent bytes");

   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= 3'd4)
      else $error("byte count out of range");

endmodule
`default_nettype wire
